>>> src/tbc_pkg.sv
// shared types, widths and constants for the barycentric classifier
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package tbc_pkg;

  localparam int COORD_BITS       = 32;
  localparam int WEIGHT_FRAC_BITS = 28;
  localparam int TOL_BITS         = 29;
  localparam int IN_BITS          = 32;
  localparam int WEIGHT_BITS      = 32;
  localparam int DIFF_BITS        = COORD_BITS + 1;
  localparam int PROD_BITS        = 2 * DIFF_BITS;
  localparam int DOT_BITS         = PROD_BITS + 2;
  localparam int HALF_BITS        = DOT_BITS / 2;
  localparam int WIDE_BITS        = 2 * DOT_BITS;
  localparam int QUOT_BITS        = WEIGHT_BITS;
  localparam int PRE_SHIFT        = QUOT_BITS - WEIGHT_FRAC_BITS;
  localparam int FIFO_DEPTH       = 4;
  localparam int FIFO_AW          = $clog2(FIFO_DEPTH);
  localparam int NUM_PRODS        = 6;

  typedef logic signed [DOT_BITS-1:0] dot_t;

  typedef struct packed {
    dot_t d00;
    dot_t d01;
    dot_t d11;
    dot_t d20;
    dot_t d21;
  } dots_t;

  typedef struct packed {
    logic signed [WEIGHT_BITS-1:0] weight_0;
    logic signed [WEIGHT_BITS-1:0] weight_1;
    logic signed [WEIGHT_BITS-1:0] weight_2;
    logic                          degenerate;
    logic                          inside_res;
    logic                          on_vertex;
    logic [1:0]                    vertex_index;
    logic                          on_edge;
    logic [1:0]                    edge_index;
  } result_t;

  // low COORD_BITS of a raw field, sign extended by one bit
  function automatic logic signed [DIFF_BITS-1:0] sext_coord(input logic [IN_BITS-1:0] raw);
    logic signed [COORD_BITS-1:0] c;
    c = raw[COORD_BITS-1:0];
    return DIFF_BITS'(c);
  endfunction

endpackage
`default_nettype wire

>>> src/tbc_front.sv
// front part: edge vectors and the five dot products, two register stages
// depends on tbc_pkg
`timescale 1ns / 1ps
`default_nettype none
module tbc_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic [tbc_pkg::IN_BITS-1:0]  a_x,
  input  wire logic [tbc_pkg::IN_BITS-1:0]  a_y,
  input  wire logic [tbc_pkg::IN_BITS-1:0]  a_z,
  input  wire logic [tbc_pkg::IN_BITS-1:0]  b_x,
  input  wire logic [tbc_pkg::IN_BITS-1:0]  b_y,
  input  wire logic [tbc_pkg::IN_BITS-1:0]  b_z,
  input  wire logic [tbc_pkg::IN_BITS-1:0]  c_x,
  input  wire logic [tbc_pkg::IN_BITS-1:0]  c_y,
  input  wire logic [tbc_pkg::IN_BITS-1:0]  c_z,
  input  wire logic [tbc_pkg::IN_BITS-1:0]  p_x,
  input  wire logic [tbc_pkg::IN_BITS-1:0]  p_y,
  input  wire logic [tbc_pkg::IN_BITS-1:0]  p_z,
  output logic [1:0]                        inflight,
  output logic                              push,
  output tbc_pkg::dots_t                    dots
);

  logic s1_valid, s2_valid;
  logic signed [tbc_pkg::DIFF_BITS-1:0] u [3];
  logic signed [tbc_pkg::DIFF_BITS-1:0] v [3];
  logic signed [tbc_pkg::DIFF_BITS-1:0] w [3];
  logic signed [tbc_pkg::PROD_BITS-1:0] uu [3];
  logic signed [tbc_pkg::PROD_BITS-1:0] uv [3];
  logic signed [tbc_pkg::PROD_BITS-1:0] vv [3];
  logic signed [tbc_pkg::PROD_BITS-1:0] wu [3];
  logic signed [tbc_pkg::PROD_BITS-1:0] wv [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

  // stage 1: differences against corner a
  always_ff @(posedge clk) begin
    u[0] <= tbc_pkg::sext_coord(b_x) - tbc_pkg::sext_coord(a_x);
    u[1] <= tbc_pkg::sext_coord(b_y) - tbc_pkg::sext_coord(a_y);
    u[2] <= tbc_pkg::sext_coord(b_z) - tbc_pkg::sext_coord(a_z);
    v[0] <= tbc_pkg::sext_coord(c_x) - tbc_pkg::sext_coord(a_x);
    v[1] <= tbc_pkg::sext_coord(c_y) - tbc_pkg::sext_coord(a_y);
    v[2] <= tbc_pkg::sext_coord(c_z) - tbc_pkg::sext_coord(a_z);
    w[0] <= tbc_pkg::sext_coord(p_x) - tbc_pkg::sext_coord(a_x);
    w[1] <= tbc_pkg::sext_coord(p_y) - tbc_pkg::sext_coord(a_y);
    w[2] <= tbc_pkg::sext_coord(p_z) - tbc_pkg::sext_coord(a_z);
  end

  // stage 2: fifteen 33x33 products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      uu[i] <= tbc_pkg::PROD_BITS'(u[i]) * tbc_pkg::PROD_BITS'(u[i]);
      uv[i] <= tbc_pkg::PROD_BITS'(u[i]) * tbc_pkg::PROD_BITS'(v[i]);
      vv[i] <= tbc_pkg::PROD_BITS'(v[i]) * tbc_pkg::PROD_BITS'(v[i]);
      wu[i] <= tbc_pkg::PROD_BITS'(w[i]) * tbc_pkg::PROD_BITS'(u[i]);
      wv[i] <= tbc_pkg::PROD_BITS'(w[i]) * tbc_pkg::PROD_BITS'(v[i]);
    end
  end

  assign inflight = {1'b0, s1_valid} + {1'b0, s2_valid};
  assign push     = s2_valid;

  always_comb begin
    dots.d00 = tbc_pkg::DOT_BITS'(uu[0]) + tbc_pkg::DOT_BITS'(uu[1])
             + tbc_pkg::DOT_BITS'(uu[2]);
    dots.d01 = tbc_pkg::DOT_BITS'(uv[0]) + tbc_pkg::DOT_BITS'(uv[1])
             + tbc_pkg::DOT_BITS'(uv[2]);
    dots.d11 = tbc_pkg::DOT_BITS'(vv[0]) + tbc_pkg::DOT_BITS'(vv[1])
             + tbc_pkg::DOT_BITS'(vv[2]);
    dots.d20 = tbc_pkg::DOT_BITS'(wu[0]) + tbc_pkg::DOT_BITS'(wu[1])
             + tbc_pkg::DOT_BITS'(wu[2]);
    dots.d21 = tbc_pkg::DOT_BITS'(wv[0]) + tbc_pkg::DOT_BITS'(wv[1])
             + tbc_pkg::DOT_BITS'(wv[2]);
  end

endmodule
`default_nettype wire

>>> src/tbc_queue.sv
// short queue of dot product sets between front and back parts
// depends on tbc_pkg
`timescale 1ns / 1ps
`default_nettype none
module tbc_queue (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire tbc_pkg::dots_t             wr_data,
  input  wire logic                       rd_en,
  output tbc_pkg::dots_t                  rd_data,
  output logic                            not_empty,
  output logic [tbc_pkg::FIFO_AW:0]       count
);

  tbc_pkg::dots_t mem [tbc_pkg::FIFO_DEPTH];
  logic [tbc_pkg::FIFO_AW-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (tbc_pkg::FIFO_AW + 1)'(wr_en) - (tbc_pkg::FIFO_AW + 1)'(rd_en);
    end
  end

  assign rd_data   = mem[rd_ptr];
  assign not_empty = (count != '0);

endmodule
`default_nettype wire

>>> src/tbc_back.sv
// back part: wide products, cramer solve by long division, weights and classification
// depends on tbc_pkg
`timescale 1ns / 1ps
`default_nettype none
module tbc_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  input  wire tbc_pkg::dots_t                q_data,
  input  wire logic [tbc_pkg::TOL_BITS-1:0]  tolerance,
  output logic                               q_pop,
  output logic                               res_valid,
  output tbc_pkg::result_t                   res
);

  localparam int HB = tbc_pkg::HALF_BITS;
  localparam int WB = tbc_pkg::WIDE_BITS;
  localparam int DB = tbc_pkg::DOT_BITS;
  localparam int NP = tbc_pkg::NUM_PRODS;
  localparam int EB = tbc_pkg::WEIGHT_BITS + 2;
  localparam logic signed [EB-1:0] W_MAX = (EB'(1) <<< (tbc_pkg::WEIGHT_BITS - 1)) - EB'(1);
  localparam logic signed [EB-1:0] W_MIN = -(EB'(1) <<< (tbc_pkg::WEIGHT_BITS - 1));

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_COMB, S_PREP, S_DIV, S_DONE} state_t;

  state_t state;
  logic [2:0] step;
  logic [1:0] pshift;
  logic [4:0] cnt;
  logic [DB-1:0] opa [NP];
  logic [DB-1:0] opb [NP];
  logic          negp [NP];
  logic [DB-1:0] prod [NP];
  logic [WB-1:0] acc [NP];
  logic [WB-1:0] den, mag1, mag2, rem1, rem2;
  logic          neg1, neg2, big1, big2, degen;
  logic [tbc_pkg::QUOT_BITS-1:0] q1, q2, nl1, nl2;

  logic signed [WB-1:0] sp [NP];
  logic signed [WB-1:0] den_s, n1_s, n2_s;
  logic [WB-1:0] sh1, sh2;

  function automatic logic [DB-1:0] mag_of(input tbc_pkg::dot_t d);
    return d[DB-1] ? DB'(-d) : DB'(d);
  endfunction

  function automatic logic signed [EB-1:0] to_weight(input logic [tbc_pkg::QUOT_BITS-1:0] q,
                                                    input logic big, input logic neg);
    logic signed [EB-1:0] r;
    if (!neg) begin
      if (big || q[tbc_pkg::QUOT_BITS-1]) r = EB'({1'b0, {(tbc_pkg::WEIGHT_BITS-1){1'b1}}});
      else r = EB'({1'b0, q});
    end else begin
      if (big || (q > {1'b1, {(tbc_pkg::QUOT_BITS-1){1'b0}}}))
        r = -(EB'({1'b1, {(tbc_pkg::WEIGHT_BITS-1){1'b0}}}));
      else r = -(EB'({1'b0, q}));
    end
    return r;
  endfunction

  always_comb begin
    for (int k = 0; k < NP; k++) begin
      sp[k] = negp[k] ? -$signed(acc[k]) : $signed(acc[k]);
    end
    den_s = sp[0] - sp[1];
    n2_s  = sp[2] - sp[3];
    n1_s  = sp[4] - sp[5];
    sh1   = {rem1[WB-2:0], nl1[tbc_pkg::QUOT_BITS-1]};
    sh2   = {rem2[WB-2:0], nl2[tbc_pkg::QUOT_BITS-1]};
  end

  // result formation
  logic signed [EB-1:0] w0e, w1e, w2e, w0s, tole, onee;
  logic g0, g1, g2, ins;
  always_comb begin
    onee = EB'(1) <<< tbc_pkg::WEIGHT_FRAC_BITS;
    tole = EB'({1'b0, tolerance});
    w1e  = degen ? '0 : to_weight(q1, big1, neg1);
    w2e  = degen ? '0 : to_weight(q2, big2, neg2);
    w0s  = onee - w1e - w2e;
    if (degen) w0e = '0;
    else if (w0s > W_MAX) w0e = W_MAX;
    else if (w0s < W_MIN) w0e = W_MIN;
    else w0e = w0s;
    ins = !degen
        && !(w0e < -tole) && !(w0e > onee + tole)
        && !(w1e < -tole) && !(w1e > onee + tole)
        && !(w2e < -tole) && !(w2e > onee + tole);
    g0 = w0e > tole;
    g1 = w1e > tole;
    g2 = w2e > tole;
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      step      <= '0;
      cnt       <= '0;
    end else begin
      res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            step  <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          step <= step + 3'd1;
          if (step == 3'd4) begin
            state <= S_COMB;
          end
        end
        S_COMB: state <= S_PREP;
        S_PREP: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          res_valid        <= 1'b1;
          res.weight_0     <= tbc_pkg::WEIGHT_BITS'(w0e);
          res.weight_1     <= tbc_pkg::WEIGHT_BITS'(w1e);
          res.weight_2     <= tbc_pkg::WEIGHT_BITS'(w2e);
          res.degenerate   <= degen;
          res.inside_res   <= ins;
          res.on_vertex    <= (g0 && !g1 && !g2) || (g1 && !g0 && !g2) || (g2 && !g0 && !g1);
          res.vertex_index <= (g1 && !g0 && !g2) ? 2'd1 : (g2 && !g0 && !g1) ? 2'd2 : 2'd0;
          res.on_edge      <= (g0 && g1 && !g2) || (g1 && g2 && !g0) || (g2 && g0 && !g1);
          res.edge_index   <= (g1 && g2 && !g0) ? 2'd1 : (g2 && g0 && !g1) ? 2'd2 : 2'd0;
          state            <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        opa[0] <= mag_of(q_data.d00); opb[0] <= mag_of(q_data.d11);
        opa[1] <= mag_of(q_data.d01); opb[1] <= mag_of(q_data.d01);
        opa[2] <= mag_of(q_data.d00); opb[2] <= mag_of(q_data.d21);
        opa[3] <= mag_of(q_data.d01); opb[3] <= mag_of(q_data.d20);
        opa[4] <= mag_of(q_data.d11); opb[4] <= mag_of(q_data.d20);
        opa[5] <= mag_of(q_data.d01); opb[5] <= mag_of(q_data.d21);
        negp[0] <= q_data.d00[DB-1] ^ q_data.d11[DB-1];
        negp[1] <= 1'b0;
        negp[2] <= q_data.d00[DB-1] ^ q_data.d21[DB-1];
        negp[3] <= q_data.d01[DB-1] ^ q_data.d20[DB-1];
        negp[4] <= q_data.d11[DB-1] ^ q_data.d20[DB-1];
        negp[5] <= q_data.d01[DB-1] ^ q_data.d21[DB-1];
        for (int k = 0; k < NP; k++) acc[k] <= '0;
      end
      S_MUL: begin
        // one half-by-half partial product per lane per cycle, added in the following cycle
        for (int k = 0; k < NP; k++) begin
          if (step != 3'd4) begin
            prod[k] <= DB'(opa[k][HB*step[1] +: HB]) * DB'(opb[k][HB*step[0] +: HB]);
          end
          if (step != 3'd0) begin
            acc[k] <= acc[k] + (WB'(prod[k]) << (HB * pshift));
          end
        end
        pshift <= {1'b0, step[1]} + {1'b0, step[0]};
      end
      S_COMB: begin
        den   <= den_s;
        degen <= (den_s == '0);
        neg1  <= n1_s[WB-1];
        neg2  <= n2_s[WB-1];
        mag1  <= n1_s[WB-1] ? WB'(-n1_s) : WB'(n1_s);
        mag2  <= n2_s[WB-1] ? WB'(-n2_s) : WB'(n2_s);
      end
      S_PREP: begin
        // quotient fits 32 bits unless the numerator reaches den << PRE_SHIFT
        big1 <= mag1 >= (den << tbc_pkg::PRE_SHIFT);
        big2 <= mag2 >= (den << tbc_pkg::PRE_SHIFT);
        rem1 <= mag1 >> tbc_pkg::PRE_SHIFT;
        rem2 <= mag2 >> tbc_pkg::PRE_SHIFT;
        nl1  <= {mag1[tbc_pkg::PRE_SHIFT-1:0], {tbc_pkg::WEIGHT_FRAC_BITS{1'b0}}};
        nl2  <= {mag2[tbc_pkg::PRE_SHIFT-1:0], {tbc_pkg::WEIGHT_FRAC_BITS{1'b0}}};
        q1   <= '0;
        q2   <= '0;
      end
      S_DIV: begin
        nl1 <= nl1 << 1;
        nl2 <= nl2 << 1;
        if (sh1 >= den) begin
          rem1 <= sh1 - den;
          q1   <= {q1[tbc_pkg::QUOT_BITS-2:0], 1'b1};
        end else begin
          rem1 <= sh1;
          q1   <= {q1[tbc_pkg::QUOT_BITS-2:0], 1'b0};
        end
        if (sh2 >= den) begin
          rem2 <= sh2 - den;
          q2   <= {q2[tbc_pkg::QUOT_BITS-2:0], 1'b1};
        end else begin
          rem2 <= sh2;
          q2   <= {q2[tbc_pkg::QUOT_BITS-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> src/triangle_barycentric_classify.sv
// top level: barycentric weights and classification of a point against a 3d triangle
// depends on tbc_pkg, tbc_front, tbc_queue, tbc_back
`timescale 1ns / 1ps
`default_nettype none
// An item (corners a, b, c and point p, signed Q16.16) is taken at a clock edge with
// start high and busy low. The front part forms the five dot products through its
// difference and product registers and drops them into a four-entry queue, so items
// keep being taken while the back part works. The back part takes one item at a time:
// it pops the item from the queue, forms 34x34 partial products for the six wide
// products, runs the setup states S_COMB and S_PREP, then restoring division (both
// weights in parallel, one quotient bit per cycle), and finally forms the result
// before it pops the next item. That loop sets the sustained rate. busy goes high
// once the queue and the two front stages hold four items.
// Each result shows on the result ports for exactly one cycle with result_valid high;
// the receiver cannot stall it. tolerance is written through cfg_valid/cfg_ready
// (always ready) and must only change while the block is idle.
module triangle_barycentric_classify (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [31:0]                         a_x,
  input  wire logic [31:0]                         a_y,
  input  wire logic [31:0]                         a_z,
  input  wire logic [31:0]                         b_x,
  input  wire logic [31:0]                         b_y,
  input  wire logic [31:0]                         b_z,
  input  wire logic [31:0]                         c_x,
  input  wire logic [31:0]                         c_y,
  input  wire logic [31:0]                         c_z,
  input  wire logic [31:0]                         p_x,
  input  wire logic [31:0]                         p_y,
  input  wire logic [31:0]                         p_z,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [tbc_pkg::TOL_BITS-1:0]        cfg_data,
  output logic                                     result_valid,
  output logic signed [31:0]                       weight_0,
  output logic signed [31:0]                       weight_1,
  output logic signed [31:0]                       weight_2,
  output logic                                     degenerate,
  output logic                                     inside_res,
  output logic                                     on_vertex,
  output logic [1:0]                               vertex_index,
  output logic                                     on_edge,
  output logic [1:0]                               edge_index
);

  // tolerance register, unsigned Q1.28 slack
  logic [tbc_pkg::TOL_BITS-1:0] tolerance;

  logic                          accept;
  logic [1:0]                    inflight;
  logic                          push;
  tbc_pkg::dots_t                push_dots;
  tbc_pkg::dots_t                pop_dots;
  logic                          q_nonempty;
  logic                          q_pop;
  logic [tbc_pkg::FIFO_AW:0]     q_count;
  tbc_pkg::result_t              res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= '0;
    end else if (cfg_valid && cfg_ready) begin
      tolerance <= cfg_data;
    end
  end

  // hold off new items when the queue could not absorb them together with everything already in flight
  assign busy   = ((tbc_pkg::FIFO_AW + 2)'(q_count) + (tbc_pkg::FIFO_AW + 2)'(inflight))
                  >= (tbc_pkg::FIFO_AW + 2)'(tbc_pkg::FIFO_DEPTH);
  assign accept = start && !busy;

  tbc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .a_x      (a_x),
    .a_y      (a_y),
    .a_z      (a_z),
    .b_x      (b_x),
    .b_y      (b_y),
    .b_z      (b_z),
    .c_x      (c_x),
    .c_y      (c_y),
    .c_z      (c_z),
    .p_x      (p_x),
    .p_y      (p_y),
    .p_z      (p_z),
    .inflight (inflight),
    .push     (push),
    .dots     (push_dots)
  );

  tbc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (push),
    .wr_data   (push_dots),
    .rd_en     (q_pop),
    .rd_data   (pop_dots),
    .not_empty (q_nonempty),
    .count     (q_count)
  );

  tbc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_nonempty),
    .q_data    (pop_dots),
    .tolerance (tolerance),
    .q_pop     (q_pop),
    .res_valid (result_valid),
    .res       (res)
  );

  // result fields straight from the back part's output register
  assign weight_0     = res.weight_0;
  assign weight_1     = res.weight_1;
  assign weight_2     = res.weight_2;
  assign degenerate   = res.degenerate;
  assign inside_res   = res.inside_res;
  assign on_vertex    = res.on_vertex;
  assign vertex_index = res.vertex_index;
  assign on_edge      = res.on_edge;
  assign edge_index   = res.edge_index;

endmodule
`default_nettype wire
